// ===== rtl/core/ultrasonic_echo_ranger_max_core_assert.svh =====
// Assertion macros for the echo ranger core.
// Depends on nothing; the asserting modules include this header by file name.
`ifndef ULTRASONIC_ECHO_RANGER_MAX_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_MAX_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define UERM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uerm: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define UERM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uerm: next-cycle check failed");

`endif

// ===== rtl/core/uerm_pkg.sv =====
// Shared types and constants of the echo ranger core.
// No dependencies; used by the channel interfaces and all modules.
package uerm_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int REG_WIDTH       = 24;
  localparam int RCOUNT_WIDTH    = 4;
  localparam int SCALE_WIDTH     = 19;
  localparam int DIST_WIDTH      = 27;
  localparam int CFG_IDX_WIDTH   = 3;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PRE_LOW       = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PULSE         = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SLOT          = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_READING_COUNT = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCALE         = 3'd4;

  // Register reset values
  localparam logic [REG_WIDTH-1:0]    PRE_LOW_RST       = 24'd2000;
  localparam logic [REG_WIDTH-1:0]    PULSE_RST         = 24'd10000;
  localparam logic [REG_WIDTH-1:0]    SLOT_RST          = 24'd200000;
  localparam logic [RCOUNT_WIDTH-1:0] READING_COUNT_RST = 4'd5;
  localparam logic [SCALE_WIDTH-1:0]  SCALE_RST         = 19'd287722;

  // Phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PRELOW   = 3'd1;
  localparam logic [2:0] PH_PULSE    = 3'd2;
  localparam logic [2:0] PH_WAITRISE = 3'd3;
  localparam logic [2:0] PH_HIGH     = 3'd4;
  localparam logic [2:0] PH_SLOTWAIT = 3'd5;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_word_t;

  typedef struct packed {
    logic                  trigger;
    logic                  busy_res;
    logic                  sample_valid;
    logic [DIST_WIDTH-1:0] sample_distance;
    logic                  done_res;
    logic [DIST_WIDTH-1:0] max_distance;
  } result_word_t;

endpackage

// ===== rtl/core/uerm_tick_if.sv =====
// Valid/ready channel carrying one timebase tick word.
// Depends on uerm_pkg.
interface uerm_tick_if;
  logic                   valid;
  logic                   ready;
  uerm_pkg::tick_word_t   word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/core/uerm_result_if.sv =====
// Valid/ready channel carrying one result word per tick.
// Depends on uerm_pkg.
interface uerm_result_if;
  logic                   valid;
  logic                   ready;
  uerm_pkg::result_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ===== rtl/core/uerm_scale.sv =====
// Echo width to distance: multiply by Q0.24 factor, round half up to Q8, saturate.
// Depends on uerm_pkg.
module uerm_scale #(
  parameter int COUNT_WIDTH = uerm_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0]           width,
  input  logic [uerm_pkg::SCALE_WIDTH-1:0] scale,
  output logic [uerm_pkg::DIST_WIDTH-1:0]  distance
);

  localparam int PRODW = COUNT_WIDTH + uerm_pkg::SCALE_WIDTH;
  localparam int SUMW  = PRODW + 1;
  localparam int DW    = SUMW - 16;
  localparam int EXW   = (DW > uerm_pkg::DIST_WIDTH + 1) ? DW : uerm_pkg::DIST_WIDTH + 1;

  logic [PRODW-1:0] prod;
  logic [SUMW-1:0]  sum;
  logic [DW-1:0]    d_wide;
  logic [EXW-1:0]   d_ext;

  assign prod   = PRODW'(width) * PRODW'(scale);
  assign sum    = SUMW'(prod) + SUMW'(1 << 15);
  assign d_wide = sum[SUMW-1:16];
  assign d_ext  = EXW'(d_wide);
  // clamp to full scale of the distance field
  assign distance = (d_ext > EXW'(uerm_pkg::DIST_MAX)) ? uerm_pkg::DIST_MAX
                                                      : d_ext[uerm_pkg::DIST_WIDTH-1:0];

endmodule

// ===== rtl/core/ultrasonic_echo_ranger_max_core.sv =====
// Top level of the ultrasonic echo ranger: sequencer, counters, output register.
// Depends on uerm_pkg, uerm_tick_if, uerm_result_if, uerm_scale and the assert header.
//
// Usage:
//   tick   - sink channel, one word per timebase tick: start_req and the sampled
//            echo level. A start while idle runs reading_count readings (at least
//            one), one per slot of at least slot_ticks ticks: trigger low, trigger
//            high, wait for the echo to rise, count its high width.
//   result - source channel, exactly one word per accepted tick: trigger level,
//            busy, per-reading distance (cm, 8 fraction bits), done and the
//            running maximum of the series.
//   cfg    - write port (cfg_we, cfg_index, cfg_data); write only while idle.
// The result word of an accepted tick is loaded into the result register by the accepting edge.
// Throughput: one tick per cycle while the result side is not stalled; the logic between
//   the state registers and the result register is the sequencer's next-state logic and
//   one width-by-scale multiply with its round, clamp and max compare.
// Stall: the result register holds its word while result.ready is low, and
//   tick.ready drops until it is taken, so no word is lost or repeated.
// Reset: rst (synchronous) returns the sequencer to idle, clears counters and
//   the maximum, loads the register defaults and empties the result register.
`include "ultrasonic_echo_ranger_max_core_assert.svh"

module ultrasonic_echo_ranger_max_core #(
  parameter int COUNT_WIDTH = uerm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  uerm_tick_if.sink                          tick,
  uerm_result_if.source                      result,
  input  logic                               cfg_we,
  input  logic [uerm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [uerm_pkg::REG_WIDTH-1:0]     cfg_data
);

  localparam int RW   = uerm_pkg::REG_WIDTH;
  localparam int CNTW = uerm_pkg::RCOUNT_WIDTH;
  localparam int DSTW = uerm_pkg::DIST_WIDTH;
  localparam int CMPW = (COUNT_WIDTH > RW) ? COUNT_WIDTH : RW;

  // Configuration registers
  logic [RW-1:0]                    pre_low_ticks;
  logic [RW-1:0]                    pulse_ticks;
  logic [RW-1:0]                    slot_ticks;
  logic [CNTW-1:0]                  reading_count;
  logic [uerm_pkg::SCALE_WIDTH-1:0] scale_q24;

  // Sequencer state
  logic [2:0]             phase, phase_next;
  logic [COUNT_WIDTH-1:0] phase_ticks, phase_ticks_next;
  logic [COUNT_WIDTH-1:0] slot_elapsed, slot_elapsed_next;
  logic [COUNT_WIDTH-1:0] echo_width, echo_width_next;
  logic [CNTW-1:0]        reading_index, reading_index_next;
  logic [DSTW-1:0]        best_distance, best_distance_next;

  // Output register
  logic                   out_valid;
  uerm_pkg::result_word_t out_word;
  uerm_pkg::result_word_t word_next;

  logic            accept;
  logic [DSTW-1:0] width_distance;
  logic            start_now;
  logic [CNTW:0]   index_inc;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // A saturated counter counts as reaching any limit.
  function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [RW-1:0] lim);
    reached = (CMPW'(c) >= CMPW'(lim)) || (c == '1);
  endfunction

  assign tick.ready   = !out_valid || result.ready;
  assign accept       = tick.valid && tick.ready;
  assign result.valid = out_valid;
  assign result.word  = out_word;

  // Distance of the width counted so far; used on the tick the echo falls.
  uerm_scale #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scale (
    .width    (echo_width),
    .scale    (scale_q24),
    .distance (width_distance)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_low_ticks <= uerm_pkg::PRE_LOW_RST;
      pulse_ticks   <= uerm_pkg::PULSE_RST;
      slot_ticks    <= uerm_pkg::SLOT_RST;
      reading_count <= uerm_pkg::READING_COUNT_RST;
      scale_q24     <= uerm_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uerm_pkg::REG_PRE_LOW:       pre_low_ticks <= cfg_data;
        uerm_pkg::REG_PULSE:         pulse_ticks   <= cfg_data;
        uerm_pkg::REG_SLOT:          slot_ticks    <= cfg_data;
        uerm_pkg::REG_READING_COUNT: reading_count <= cfg_data[CNTW-1:0];
        uerm_pkg::REG_SCALE:         scale_q24     <= cfg_data[uerm_pkg::SCALE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the sequencer
  always_comb begin
    start_now = (phase == uerm_pkg::PH_IDLE) && tick.word.start_req;
    index_inc = (CNTW + 1)'(reading_index) + (CNTW + 1)'(1);

    // a start clears the series state and enters the first pre-low tick
    phase_next         = start_now ? uerm_pkg::PH_PRELOW : phase;
    phase_ticks_next   = start_now ? '0 : phase_ticks;
    slot_elapsed_next  = start_now ? '0 : slot_elapsed;
    echo_width_next    = start_now ? '0 : echo_width;
    reading_index_next = start_now ? '0 : reading_index;
    best_distance_next = start_now ? '0 : best_distance;

    word_next = '0;

    if (phase_next != uerm_pkg::PH_IDLE) begin
      word_next.busy_res = 1'b1;
      slot_elapsed_next  = sat_inc(slot_elapsed_next);
      case (phase_next)
        uerm_pkg::PH_PRELOW: begin
          phase_ticks_next = sat_inc(phase_ticks_next);
          if (reached(phase_ticks_next, pre_low_ticks)) begin
            phase_next       = uerm_pkg::PH_PULSE;
            phase_ticks_next = '0;
          end
        end
        uerm_pkg::PH_PULSE: begin
          word_next.trigger = 1'b1;
          phase_ticks_next  = sat_inc(phase_ticks_next);
          if (reached(phase_ticks_next, pulse_ticks)) begin
            phase_next       = uerm_pkg::PH_WAITRISE;
            phase_ticks_next = '0;
          end
        end
        uerm_pkg::PH_WAITRISE: begin
          if (tick.word.echo) begin
            echo_width_next = COUNT_WIDTH'(1);
            phase_next      = uerm_pkg::PH_HIGH;
          end
        end
        uerm_pkg::PH_HIGH: begin
          if (tick.word.echo) begin
            echo_width_next = sat_inc(echo_width);
          end else begin
            // echo fell: report the reading and keep the larger distance
            word_next.sample_valid    = 1'b1;
            word_next.sample_distance = width_distance;
            if (width_distance > best_distance) begin
              best_distance_next = width_distance;
            end
            phase_next = uerm_pkg::PH_SLOTWAIT;
          end
        end
        default: begin
          // slot wait: advance to the next reading or finish the series
          if (reached(slot_elapsed_next, slot_ticks)) begin
            if (index_inc >= (CNTW + 1)'(reading_count)) begin
              word_next.done_res = 1'b1;
              phase_next         = uerm_pkg::PH_IDLE;
              reading_index_next = '0;
            end else begin
              reading_index_next = index_inc[CNTW-1:0];
              phase_next         = uerm_pkg::PH_PRELOW;
            end
            slot_elapsed_next = '0;
            phase_ticks_next  = '0;
            echo_width_next   = '0;
          end
        end
      endcase
    end

    word_next.max_distance = best_distance_next;
  end

  // State advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uerm_pkg::PH_IDLE;
      phase_ticks   <= '0;
      slot_elapsed  <= '0;
      echo_width    <= '0;
      reading_index <= '0;
      best_distance <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      phase_ticks   <= phase_ticks_next;
      slot_elapsed  <= slot_elapsed_next;
      echo_width    <= echo_width_next;
      reading_index <= reading_index_next;
      best_distance <= best_distance_next;
    end
  end

  // Result register: load on accept, drop once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= word_next;
    end
  end

  // Never take a tick while an untaken word sits in the result register
  `UERM_ASSERT_NOW(a_no_overwrite, clk, rst, out_valid && !result.ready, !tick.ready)
  // Every accepted tick yields a word on the next cycle
  `UERM_ASSERT_NEXT(a_word_follows, clk, rst, accept, out_valid)
  // A distance is only reported with its valid flag
  `UERM_ASSERT_NOW(a_dist_gated, clk, rst, out_valid && !out_word.sample_valid, out_word.sample_distance == '0)
  // The running maximum covers the reading just reported
  `UERM_ASSERT_NOW(a_max_covers, clk, rst, out_valid && out_word.sample_valid, out_word.max_distance >= out_word.sample_distance)
  // Readings, the trigger and the done flag only occur inside a series
  `UERM_ASSERT_NOW(a_busy_covers, clk, rst, out_valid && (out_word.sample_valid || out_word.trigger || out_word.done_res), out_word.busy_res)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the ultrasonic echo ranger core.
// Depends on uerm_pkg, uerm_tick_if, uerm_result_if and ultrasonic_echo_ranger_max_core.
`timescale 1ns / 1ps

module testbench;
  import uerm_pkg::*;

  localparam logic [REG_WIDTH-1:0] CNT_FULL = '1;  // counter full scale at 24 bits

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [REG_WIDTH-1:0]     cfg_data;

  uerm_tick_if   tick_ch ();
  uerm_result_if result_ch ();

  ultrasonic_echo_ranger_max_core dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies held by the predictor
  logic [REG_WIDTH-1:0]    pre_low_reg  = PRE_LOW_RST;
  logic [REG_WIDTH-1:0]    pulse_reg    = PULSE_RST;
  logic [REG_WIDTH-1:0]    slot_reg     = SLOT_RST;
  logic [RCOUNT_WIDTH-1:0] readings_reg = READING_COUNT_RST;
  logic [SCALE_WIDTH-1:0]  scale_reg    = SCALE_RST;

  // Sequencer state of the predictor
  logic [2:0]              ph         = PH_IDLE;
  logic [REG_WIDTH-1:0]    ph_ticks   = '0;
  logic [REG_WIDTH-1:0]    slot_el    = '0;
  logic [REG_WIDTH-1:0]    echo_len   = '0;
  logic [RCOUNT_WIDTH-1:0] reading_no = '0;
  logic [DIST_WIDTH-1:0]   best_dist  = '0;

  result_word_t expected_ranging[$];
  int           errors    = 0;
  bit           gaps_on   = 1'b1;
  bit           stalls_on = 1'b1;
  int           rise_pct  = 30;   // odds of the echo rising on a wait tick
  int           hold_pct  = 80;   // odds of the echo staying high

  // Clock; the single reset at the start of the run comes from the stimulus block
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count a failure; report only the first ten in full
  function automatic bit note_mismatch();
    errors++;
    return errors <= 10;
  endfunction

  function automatic logic [REG_WIDTH-1:0] sat_up(input logic [REG_WIDTH-1:0] v);
    return (v == CNT_FULL) ? v : v + 1'b1;
  endfunction

  function automatic bit hit(input logic [REG_WIDTH-1:0] cnt, input logic [REG_WIDTH-1:0] lim);
    return (cnt >= lim) || (cnt == CNT_FULL);
  endfunction

  // Advance the predicted sequencer by one accepted tick and return its result word
  function automatic result_word_t predict_ranging(input tick_word_t w);
    result_word_t r;
    logic [63:0]  dist_full;
    r = '0;
    if (ph == PH_IDLE && w.start_req) begin
      ph         = PH_PRELOW;
      ph_ticks   = '0;
      slot_el    = '0;
      echo_len   = '0;
      reading_no = '0;
      best_dist  = '0;
    end
    if (ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      slot_el    = sat_up(slot_el);
      case (ph)
        PH_PRELOW: begin
          ph_ticks = sat_up(ph_ticks);
          if (hit(ph_ticks, pre_low_reg)) begin
            ph       = PH_PULSE;
            ph_ticks = '0;
          end
        end
        PH_PULSE: begin
          r.trigger = 1'b1;
          ph_ticks  = sat_up(ph_ticks);
          if (hit(ph_ticks, pulse_reg)) begin
            ph       = PH_WAITRISE;
            ph_ticks = '0;
          end
        end
        PH_WAITRISE: begin
          if (w.echo) begin
            echo_len = REG_WIDTH'(1);
            ph       = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (w.echo) begin
            echo_len = sat_up(echo_len);
          end else begin
            // Round half up, then clamp to the distance width
            dist_full = (64'(echo_len) * 64'(scale_reg) + 64'd32768) >> 16;
            r.sample_distance = (dist_full > 64'(DIST_MAX)) ? DIST_MAX
                                                            : dist_full[DIST_WIDTH-1:0];
            r.sample_valid    = 1'b1;
            if (r.sample_distance > best_dist) best_dist = r.sample_distance;
            ph = PH_SLOTWAIT;
          end
        end
        default: begin
          if (slot_el >= slot_reg || slot_el == CNT_FULL) begin
            if (5'(reading_no) + 5'd1 >= 5'(readings_reg)) begin
              r.done_res = 1'b1;
              ph         = PH_IDLE;
              reading_no = '0;
            end else begin
              reading_no = reading_no + 1'b1;
              ph         = PH_PRELOW;
            end
            slot_el  = '0;
            ph_ticks = '0;
            echo_len = '0;
          end
        end
      endcase
    end
    r.max_distance = best_dist;
    return r;
  endfunction

  // Pick the next tick word from where the sequencer stands: mostly well-formed
  // echoes, some pure noise, and starts that land while busy.
  function automatic tick_word_t make_tick(input bit allow_start);
    tick_word_t w;
    w.start_req = (ph == PH_IDLE) ? (allow_start && $urandom_range(0, 1) == 0)
                                  : ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) begin
      w.echo = 1'($urandom_range(0, 1));
    end else begin
      case (ph)
        PH_WAITRISE: w.echo = ($urandom_range(0, 99) < rise_pct);
        PH_HIGH:     w.echo = ($urandom_range(0, 99) < hold_pct);
        default:     w.echo = 1'($urandom_range(0, 1));
      endcase
    end
    return w;
  endfunction

  // Send one tick word: optional idle gap, hold valid until accepted, then
  // record the expected result. Entered and left at a falling edge.
  task automatic send_tick(input tick_word_t w);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.word  <= w;
    do @(posedge clk); while (!tick_ch.ready);
    expected_ranging.push_back(predict_ranging(w));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word has come out.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (expected_ranging.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [REG_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Write all five registers back to back; only called while idle
  task automatic program_regs(input logic [REG_WIDTH-1:0] pre, input logic [REG_WIDTH-1:0] pulse,
                              input logic [REG_WIDTH-1:0] slot,
                              input logic [RCOUNT_WIDTH-1:0] count,
                              input logic [SCALE_WIDTH-1:0] scale);
    put_reg(REG_PRE_LOW, pre);
    put_reg(REG_PULSE, pulse);
    put_reg(REG_SLOT, slot);
    put_reg(REG_READING_COUNT, REG_WIDTH'(count));
    put_reg(REG_SCALE, REG_WIDTH'(scale));
    cfg_we       <= 1'b0;
    pre_low_reg  = pre;
    pulse_reg    = pulse;
    slot_reg     = slot;
    readings_reg = count;
    scale_reg    = scale;
    @(negedge clk);
  endtask

  // Random ticks, then finish any series in flight and drain
  task automatic run_random(input int n);
    repeat (n) send_tick(make_tick(1'b1));
    while (ph != PH_IDLE) send_tick(make_tick(1'b0));
    settle();
  endtask

  task automatic program_small_random();
    program_regs(REG_WIDTH'($urandom_range(0, 4)), REG_WIDTH'($urandom_range(0, 4)),
                 REG_WIDTH'($urandom_range(0, 30)), RCOUNT_WIDTH'($urandom_range(0, 4)),
                 SCALE_WIDTH'($urandom_range(0, 524287)));
  endtask

  // Under the reset defaults an idle block answers every tick with zeros
  task automatic test_idle_after_reset();
    tick_word_t w;
    for (int i = 0; i < 4; i++) begin
      w.start_req = 1'b0;
      w.echo      = i[0];
      send_tick(w);
    end
    settle();
  endtask

  // Zero tick registers act as one, zero readings as one; starts while busy
  // and an early echo are ignored, and an echo already high on the first
  // wait tick counts as the rise. Full-scale factor.
  task automatic test_zero_registers();
    tick_word_t w;
    program_regs('0, '0, '0, '0, '1);
    for (int i = 0; i < 6; i++) begin
      w.start_req = (i < 3) || (i == 5);
      w.echo      = (i < 4);
      send_tick(w);
    end
    settle();
  endtask

  // First echo outlasts its slot, so the next reading starts straight after its slot
  // wait; the second, shorter echo must not lower the maximum.
  task automatic test_slot_overrun();
    localparam logic [14:0] ECHO_SEQ = 15'b001000001111000;  // bit i = tick i
    tick_word_t w;
    program_regs(24'd1, 24'd2, 24'd3, 4'd2, SCALE_RST);
    for (int i = 0; i < 15; i++) begin
      w.start_req = (i == 0);
      w.echo      = ECHO_SEQ[i];
      send_tick(w);
    end
    settle();
  endtask

  task automatic test_random_short_slots();
    repeat (3) begin
      rise_pct = $urandom_range(10, 60);
      hold_pct = $urandom_range(50, 90);
      program_small_random();
      run_random(110);
    end
  endtask

  // Longest series at the full-scale factor
  task automatic test_long_series();
    rise_pct = 40;
    hold_pct = 85;
    program_regs(REG_WIDTH'($urandom_range(1, 3)), REG_WIDTH'($urandom_range(1, 3)),
                 REG_WIDTH'($urandom_range(8, 20)), 4'd15, '1);
    run_random(110);
  endtask

  task automatic test_scale_zero();
    rise_pct = 30;
    hold_pct = 80;
    program_regs(REG_WIDTH'($urandom_range(1, 3)), REG_WIDTH'($urandom_range(1, 3)),
                 REG_WIDTH'($urandom_range(5, 15)), 4'd3, '0);
    run_random(110);
  endtask

  task automatic test_zero_tick_registers();
    rise_pct = 50;
    hold_pct = 70;
    program_regs('0, '0, '0, '0, SCALE_WIDTH'($urandom_range(0, 524287)));
    run_random(110);
  endtask

  // Long echoes against tiny slots keep overrunning
  task automatic test_long_echo_overrun();
    rise_pct = 40;
    hold_pct = 95;
    program_regs(REG_WIDTH'($urandom_range(0, 2)), REG_WIDTH'($urandom_range(0, 2)),
                 REG_WIDTH'($urandom_range(1, 4)), RCOUNT_WIDTH'($urandom_range(2, 6)),
                 SCALE_WIDTH'($urandom_range(0, 524287)));
    run_random(110);
  endtask

  // Full-scale tick registers: a series would take millions of ticks, so
  // hold the block idle and check it stays quiet
  task automatic test_full_scale_registers_idle();
    program_regs('1, '1, '1, 4'd15, '1);
    repeat (40) send_tick(make_tick(1'b0));
    settle();
  endtask

  // Closing stretch: no gaps and no stalls
  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    rise_pct  = 35;
    hold_pct  = 80;
    program_small_random();
    run_random(150);
  endtask

  // Result side: random ready bursts, always ready once stalls are off
  initial begin : result_pacing
    int left;
    bit hold_low;
    left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stalls_on) begin
        result_ch.ready <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else begin
        hold_low = ($urandom_range(0, 2) == 0);
        left     = hold_low ? $urandom_range(1, 18) : $urandom_range(1, 30);
        result_ch.ready <= !hold_low;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    result_word_t seen;
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen = result_ch.word;
      if (expected_ranging.size() == 0) begin
        if (note_mismatch())
          $display("unexpected result word: trig=%0b busy=%0b sv=%0b sd=%0d done=%0b max=%0d",
                   seen.trigger, seen.busy_res, seen.sample_valid, seen.sample_distance,
                   seen.done_res, seen.max_distance);
      end else begin
        want = expected_ranging.pop_front();
        if (seen.trigger !== want.trigger || seen.busy_res !== want.busy_res ||
            seen.sample_valid !== want.sample_valid ||
            seen.sample_distance !== want.sample_distance ||
            seen.done_res !== want.done_res || seen.max_distance !== want.max_distance) begin
          if (note_mismatch())
            $display({"result mismatch: exp trig=%0b busy=%0b sv=%0b sd=%0d done=%0b max=%0d",
                      " | got trig=%0b busy=%0b sv=%0b sd=%0d done=%0b max=%0d"},
                     want.trigger, want.busy_res, want.sample_valid, want.sample_distance,
                     want.done_res, want.max_distance,
                     seen.trigger, seen.busy_res, seen.sample_valid, seen.sample_distance,
                     seen.done_res, seen.max_distance);
        end
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int waited;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_PRE_LOW;
    cfg_data      <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.word  <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_after_reset();
    test_zero_registers();
    test_slot_overrun();
    test_random_short_slots();
    test_long_series();
    test_scale_zero();
    test_zero_tick_registers();
    test_long_echo_overrun();
    test_full_scale_registers_idle();
    test_back_to_back();

    // Wait out anything still owed, with a limit; leftovers are failures
    tick_ch.valid <= 1'b0;
    waited = 0;
    while (expected_ranging.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    if (expected_ranging.size() != 0) begin
      if (note_mismatch())
        $display("%0d expected result words never arrived", expected_ranging.size());
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
